>>> rtl/pfv_pkg.sv
`timescale 1ns / 1ps

package pfv_pkg;

   // heading iterations, one per stage
   localparam int CORDIC_STAGES = 16;

   // square root: one result bit per stage
   localparam int ROOT_W = 33;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 3;

   // direction cosine, unsigned Q1.30, one quotient bit per stage
   localparam int COS_W = 31;

   // gain times length
   localparam int GAIN_W = 16;
   localparam int MAG_W  = GAIN_W + ROOT_W;

   // heading datapath width
   localparam int CD_W = 35;

   // register map
   typedef enum logic [2:0] {
      CSR_CENTRE_X     = 3'd0,
      CSR_CENTRE_Y     = 3'd1,
      CSR_ATTRACT_GAIN = 3'd2,
      CSR_REPEL_GAIN   = 3'd3,
      CSR_CORE_RADIUS  = 3'd4,
      CSR_FIELD_SPREAD = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [15:0] heading;
      logic               saturated;
   } rsp_type;

   // sideband carried beside the square root
   typedef struct packed {
      logic              repel;
      logic              ox_neg;
      logic              oy_neg;
      logic [ROOT_W-1:0] ax;
      logic [ROOT_W-1:0] ay;
   } sq_side_type;

   // sideband carried beside the heading unit
   typedef struct packed {
      logic               sat;
      logic signed [31:0] fx;
      logic signed [31:0] fy;
   } cd_side_type;

   // arctangent of 2^-i, 2^31 = pi
   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:    val = 32'd536870912;
         5'd1:    val = 32'd316933406;
         5'd2:    val = 32'd167458907;
         5'd3:    val = 32'd85004756;
         5'd4:    val = 32'd42667331;
         5'd5:    val = 32'd21354465;
         5'd6:    val = 32'd10679838;
         5'd7:    val = 32'd5340245;
         5'd8:    val = 32'd2670163;
         5'd9:    val = 32'd1335087;
         5'd10:   val = 32'd667544;
         5'd11:   val = 32'd333772;
         5'd12:   val = 32'd166886;
         5'd13:   val = 32'd83443;
         5'd14:   val = 32'd41722;
         5'd15:   val = 32'd20861;
         5'd16:   val = 32'd10430;
         5'd17:   val = 32'd5215;
         5'd18:   val = 32'd2608;
         5'd19:   val = 32'd1304;
         5'd20:   val = 32'd652;
         5'd21:   val = 32'd326;
         5'd22:   val = 32'd163;
         5'd23:   val = 32'd81;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

>>> rtl/pfv_isqrt.sv
`timescale 1ns / 1ps

module pfv_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [pfv_pkg::RAD_W-1:0]   in_rad,
   input  pfv_pkg::sq_side_type        in_side,
   output logic                        out_valid,
   output logic [pfv_pkg::ROOT_W-1:0]  out_root,
   output pfv_pkg::sq_side_type        out_side
);

   localparam int N     = pfv_pkg::ROOT_W;
   localparam int RAD_W = pfv_pkg::RAD_W;
   localparam int REM_W = pfv_pkg::REM_W;

   logic [N-1:0]         vld_ff;
   logic [REM_W-1:0]     rem_ff  [N];
   logic [N-1:0]         root_ff [N];
   logic [RAD_W-1:0]     rad_ff  [N];
   pfv_pkg::sq_side_type side_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_step
      logic                 vld_prev;
      logic [REM_W-1:0]     rem_prev;
      logic [N-1:0]         root_prev;
      logic [RAD_W-1:0]     rad_prev;
      pfv_pkg::sq_side_type side_prev;
      logic [REM_W-1:0]     rem_sh;
      logic [REM_W-1:0]     trial;
      logic                 fits;
      logic [REM_W-1:0]     rem_in;
      logic [N-1:0]         root_in;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_rad;
         assign side_prev = in_side;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      // bring down two radicand bits, try root*4+1
      always_comb begin
         rem_sh  = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
         trial   = {1'b0, root_prev, 2'b01};
         fits    = (rem_sh >= trial);
         rem_in  = fits ? (rem_sh - trial) : rem_sh;
         root_in = {root_prev[N-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= {rad_prev[RAD_W-3:0], 2'b00};
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

>>> rtl/pfv_cordic.sv
`timescale 1ns / 1ps

module pfv_cordic (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  pfv_pkg::cd_side_type in_side,
   output logic                 out_valid,
   output logic [31:0]          out_angle,
   output logic                 out_zero,
   output pfv_pkg::cd_side_type out_side
);

   localparam int N  = pfv_pkg::CORDIC_STAGES;
   localparam int CW = pfv_pkg::CD_W;

   // pre-rotation into the right half plane
   logic                 pre_vld_ff;
   logic signed [CW-1:0] pre_x_ff, pre_y_ff;
   logic [31:0]          pre_z_ff;
   logic                 pre_zero_ff;
   pfv_pkg::cd_side_type pre_side_ff;

   logic signed [CW-1:0] fx_ext, fy_ext;
   logic signed [CW-1:0] pre_x_in, pre_y_in;
   logic [31:0]          pre_z_in;

   always_comb begin
      fx_ext = {{(CW-32){in_side.fx[31]}}, in_side.fx};
      fy_ext = {{(CW-32){in_side.fy[31]}}, in_side.fy};
      pre_x_in = fx_ext;
      pre_y_in = fy_ext;
      pre_z_in = 32'h0000_0000;
      if (in_side.fx[31]) begin
         if (!in_side.fy[31]) begin
            pre_x_in = fy_ext;
            pre_y_in = -fx_ext;
            pre_z_in = 32'h4000_0000;
         end else begin
            pre_x_in = -fy_ext;
            pre_y_in = fx_ext;
            pre_z_in = 32'hC000_0000;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= 1'b0;
      end else if (adv) begin
         pre_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pre_x_ff    <= pre_x_in;
         pre_y_ff    <= pre_y_in;
         pre_z_ff    <= pre_z_in;
         pre_zero_ff <= (in_side.fx == 32'sd0) && (in_side.fy == 32'sd0);
         pre_side_ff <= in_side;
      end
   end

   // vectoring iterations
   logic [N-1:0]         vld_ff;
   logic signed [CW-1:0] x_ff [N];
   logic signed [CW-1:0] y_ff [N];
   logic [31:0]          z_ff [N];
   logic [N-1:0]         zero_ff;
   pfv_pkg::cd_side_type side_ff [N];

   for (genvar i = 0; i < N; i++) begin : g_iter
      logic                 vld_prev, zero_prev;
      logic signed [CW-1:0] x_prev, y_prev, xs, ys, x_in, y_in;
      logic [31:0]          z_prev, z_in, step;
      pfv_pkg::cd_side_type side_prev;

      if (i == 0) begin : g_first
         assign vld_prev  = pre_vld_ff;
         assign x_prev    = pre_x_ff;
         assign y_prev    = pre_y_ff;
         assign z_prev    = pre_z_ff;
         assign zero_prev = pre_zero_ff;
         assign side_prev = pre_side_ff;
      end else begin : g_next
         assign vld_prev  = vld_ff[i-1];
         assign x_prev    = x_ff[i-1];
         assign y_prev    = y_ff[i-1];
         assign z_prev    = z_ff[i-1];
         assign zero_prev = zero_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      always_comb begin
         xs   = x_prev >>> i;
         ys   = y_prev >>> i;
         step = pfv_pkg::atan_entry(5'(i));
         if (!y_prev[CW-1]) begin
            x_in = x_prev + ys;
            y_in = y_prev - xs;
            z_in = z_prev + step;
         end else begin
            x_in = x_prev - ys;
            y_in = y_prev + xs;
            z_in = z_prev - step;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
            zero_ff[i] <= zero_prev;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_angle = z_ff[N-1];
   assign out_zero  = zero_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

>>> rtl/potential_field_force_vector_core.sv
`timescale 1ns / 1ps

// channel  | dir | handshake            | beat
// ---------+-----+----------------------+-------------------------------
// req      | in  | req_valid/req_stall  | kind, pos_x, pos_y
// rsp      | out | rsp_valid/rsp_stall  | force_x, force_y, heading, sat
// csr      | in  | csr_we               | csr_index, csr_wdata
//
// one beat per cycle while no rsp beat is held. the pipe holds a 33-stage
// bit-serial square root, a 31-stage divider for the cosines, then the
// heading iterations. all stages advance together, so a held rsp beat
// stalls the whole pipe and req_stall follows it. synchronous reset clears
// the valid bits and loads the register defaults; there is no clearing pass.

module potential_field_force_vector_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pfv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pfv_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata
);

   localparam int ROOT_W = pfv_pkg::ROOT_W;
   localparam int RAD_W  = pfv_pkg::RAD_W;
   localparam int COS_W  = pfv_pkg::COS_W;
   localparam int MAG_W  = pfv_pkg::MAG_W;
   localparam int GAIN_W = pfv_pkg::GAIN_W;
   localparam int MLO_W  = 25;
   localparam int MHI_W  = MAG_W - MLO_W;
   localparam int PRD_W  = MAG_W + COS_W;
   localparam int Q_W    = PRD_W - 38;

   typedef struct packed {
      logic              repel;
      logic              ox_neg;
      logic              oy_neg;
      logic              inf;
      logic              dz;
      logic [MAG_W-1:0]  mag;
   } fv_side_type;

   logic adv;
   logic rsp_valid_ff;
   pfv_pkg::rsp_type rsp_data_ff;

   // whole pipe moves unless the output beat is held
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // configuration registers
   logic [31:0]       cx_ff, cy_ff;
   logic [GAIN_W-1:0] ag_ff, rg_ff;
   logic [29:0]       rad_ff, spr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff  <= 32'd0;
         cy_ff  <= 32'd0;
         ag_ff  <= 16'd256;
         rg_ff  <= 16'd256;
         rad_ff <= 30'd65536;
         spr_ff <= 30'd131072;
      end else if (csr_we) begin
         case (csr_index)
            pfv_pkg::CSR_CENTRE_X:     cx_ff  <= csr_wdata;
            pfv_pkg::CSR_CENTRE_Y:     cy_ff  <= csr_wdata;
            pfv_pkg::CSR_ATTRACT_GAIN: ag_ff  <= csr_wdata[15:0];
            pfv_pkg::CSR_REPEL_GAIN:   rg_ff  <= csr_wdata[15:0];
            pfv_pkg::CSR_CORE_RADIUS:  rad_ff <= csr_wdata[29:0];
            pfv_pkg::CSR_FIELD_SPREAD: spr_ff <= csr_wdata[29:0];
            default: ;
         endcase
      end
   end

   // offset to centre and its magnitude per axis
   logic                 a_vld_ff;
   pfv_pkg::sq_side_type a_side_ff, a_side_in;
   logic [ROOT_W-1:0]    ox, oy;

   always_comb begin
      ox = {cx_ff[31], cx_ff} - {req_data.pos_x[31], req_data.pos_x};
      oy = {cy_ff[31], cy_ff} - {req_data.pos_y[31], req_data.pos_y};
      a_side_in.repel  = req_data.kind;
      a_side_in.ox_neg = ox[ROOT_W-1];
      a_side_in.oy_neg = oy[ROOT_W-1];
      a_side_in.ax     = ox[ROOT_W-1] ? (~ox + 1'b1) : ox;
      a_side_in.ay     = oy[ROOT_W-1] ? (~oy + 1'b1) : oy;
   end

   // squares
   logic                 b_vld_ff;
   logic [RAD_W-1:0]     b_sqx_ff, b_sqy_ff;
   pfv_pkg::sq_side_type b_side_ff;

   // sum of squares
   logic                 c_vld_ff;
   logic [RAD_W-1:0]     c_rad_ff;
   pfv_pkg::sq_side_type c_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_side_ff <= a_side_in;
         b_sqx_ff  <= a_side_ff.ax * a_side_ff.ax;
         b_sqy_ff  <= a_side_ff.ay * a_side_ff.ay;
         b_side_ff <= a_side_ff;
         c_rad_ff  <= b_sqx_ff + b_sqy_ff;
         c_side_ff <= b_side_ff;
      end
   end

   logic                 s_vld;
   logic [ROOT_W-1:0]    s_root;
   pfv_pkg::sq_side_type s_side;

   pfv_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (c_vld_ff),
      .in_rad    (c_rad_ff),
      .in_side   (c_side_ff),
      .out_valid (s_vld),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   // pick field length and gain from the distance bands
   logic [ROOT_W-1:0] r_ext, rs_ext, m_len_in;
   logic [GAIN_W-1:0] m_gain_in;
   logic              m_inf_in;

   always_comb begin
      r_ext  = {3'b000, rad_ff};
      rs_ext = {3'b000, rad_ff} + {3'b000, spr_ff};
      m_inf_in = s_side.repel && (s_root < r_ext);
      if (!s_side.repel) begin
         m_gain_in = ag_ff;
         if (s_root < r_ext) begin
            m_len_in = '0;
         end else if (s_root <= rs_ext) begin
            m_len_in = s_root - r_ext;
         end else begin
            m_len_in = {3'b000, spr_ff};
         end
      end else begin
         m_gain_in = rg_ff;
         if (s_root > rs_ext) begin
            m_len_in = '0;
         end else begin
            m_len_in = rs_ext - s_root;
         end
      end
   end

   logic                 m_vld_ff, n_vld_ff;
   logic [ROOT_W-1:0]    m_len_ff, m_d_ff, n_d_ff;
   logic [GAIN_W-1:0]    m_gain_ff;
   logic                 m_inf_ff;
   pfv_pkg::sq_side_type m_side_ff, n_side_ff;
   fv_side_type          n_fv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
         n_vld_ff <= 1'b0;
      end else if (adv) begin
         m_vld_ff <= s_vld;
         n_vld_ff <= m_vld_ff;
      end
   end

   // gain times length
   always_ff @(posedge clock) begin
      if (adv) begin
         m_len_ff       <= m_len_in;
         m_gain_ff      <= m_gain_in;
         m_inf_ff       <= m_inf_in;
         m_d_ff         <= s_root;
         m_side_ff      <= s_side;
         n_d_ff         <= m_d_ff;
         n_side_ff      <= m_side_ff;
         n_fv_ff.repel  <= m_side_ff.repel;
         n_fv_ff.ox_neg <= m_side_ff.ox_neg;
         n_fv_ff.oy_neg <= m_side_ff.oy_neg;
         n_fv_ff.inf    <= m_inf_ff;
         n_fv_ff.dz     <= (m_d_ff == '0);
         n_fv_ff.mag    <= m_gain_ff * m_len_ff;
      end
   end

   // restoring divider: |offset| * 2^30 / distance, both axes
   logic [COS_W-1:0]  dv_vld_ff;
   logic [ROOT_W-1:0] dv_d_ff  [COS_W];
   logic [ROOT_W-1:0] dv_rx_ff [COS_W];
   logic [ROOT_W-1:0] dv_ry_ff [COS_W];
   logic [COS_W-1:0]  dv_qx_ff [COS_W];
   logic [COS_W-1:0]  dv_qy_ff [COS_W];
   fv_side_type       dv_fv_ff [COS_W];

   for (genvar j = 0; j < COS_W; j++) begin : g_div
      logic              vld_prev;
      logic [ROOT_W-1:0] d_prev, rx_prev, ry_prev;
      logic [COS_W-1:0]  qx_prev, qy_prev;
      fv_side_type       fv_prev;
      logic [ROOT_W:0]   tx, ty;
      logic              gx, gy;

      if (j == 0) begin : g_first
         assign vld_prev = n_vld_ff;
         assign d_prev   = n_d_ff;
         assign rx_prev  = n_side_ff.ax;
         assign ry_prev  = n_side_ff.ay;
         assign qx_prev  = '0;
         assign qy_prev  = '0;
         assign fv_prev  = n_fv_ff;
         assign tx       = {1'b0, rx_prev};
         assign ty       = {1'b0, ry_prev};
      end else begin : g_next
         assign vld_prev = dv_vld_ff[j-1];
         assign d_prev   = dv_d_ff[j-1];
         assign rx_prev  = dv_rx_ff[j-1];
         assign ry_prev  = dv_ry_ff[j-1];
         assign qx_prev  = dv_qx_ff[j-1];
         assign qy_prev  = dv_qy_ff[j-1];
         assign fv_prev  = dv_fv_ff[j-1];
         assign tx       = {rx_prev, 1'b0};
         assign ty       = {ry_prev, 1'b0};
      end

      assign gx = (tx >= {1'b0, d_prev});
      assign gy = (ty >= {1'b0, d_prev});

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[j] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_d_ff[j]  <= d_prev;
            dv_rx_ff[j] <= gx ? ROOT_W'(tx - {1'b0, d_prev}) : tx[ROOT_W-1:0];
            dv_ry_ff[j] <= gy ? ROOT_W'(ty - {1'b0, d_prev}) : ty[ROOT_W-1:0];
            dv_qx_ff[j] <= {qx_prev[COS_W-2:0], gx};
            dv_qy_ff[j] <= {qy_prev[COS_W-2:0], gy};
            dv_fv_ff[j] <= fv_prev;
         end
      end
   end

   // partial products of magnitude and cosine
   logic              dv_vld;
   logic [COS_W-1:0]  cos_x, cos_y;
   fv_side_type       dv_fv;

   assign dv_vld = dv_vld_ff[COS_W-1];
   assign dv_fv  = dv_fv_ff[COS_W-1];
   assign cos_x  = dv_fv.dz ? COS_W'(32'h4000_0000) : dv_qx_ff[COS_W-1];
   assign cos_y  = dv_fv.dz ? '0 : dv_qy_ff[COS_W-1];

   logic                   p_vld_ff, q_vld_ff;
   logic [MHI_W+COS_W-1:0] p_hx_ff, p_hy_ff;
   logic [MLO_W+COS_W-1:0] p_lx_ff, p_ly_ff;
   fv_side_type            p_fv_ff, q_fv_ff;
   logic [Q_W-1:0]         q_x_ff, q_y_ff;
   logic [PRD_W-1:0]       prod_x, prod_y;

   assign prod_x = {p_hx_ff, {MLO_W{1'b0}}} + PRD_W'(p_lx_ff);
   assign prod_y = {p_hy_ff, {MLO_W{1'b0}}} + PRD_W'(p_ly_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
         q_vld_ff <= 1'b0;
      end else if (adv) begin
         p_vld_ff <= dv_vld;
         q_vld_ff <= p_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_hx_ff <= dv_fv.mag[MAG_W-1:MLO_W] * cos_x;
         p_lx_ff <= dv_fv.mag[MLO_W-1:0] * cos_x;
         p_hy_ff <= dv_fv.mag[MAG_W-1:MLO_W] * cos_y;
         p_ly_ff <= dv_fv.mag[MLO_W-1:0] * cos_y;
         p_fv_ff <= dv_fv;
         q_x_ff  <= prod_x[PRD_W-1:38];
         q_y_ff  <= prod_y[PRD_W-1:38];
         q_fv_ff <= p_fv_ff;
      end
   end

   // clip, apply sign, infinite case
   logic           neg_x, neg_y, ovr_x, ovr_y;
   logic [Q_W-1:0] lim_x, lim_y;
   logic [31:0]    v_x, v_y;
   pfv_pkg::cd_side_type f_side_in, f_side_ff;
   logic           f_vld_ff;

   always_comb begin
      neg_x = q_fv_ff.ox_neg ^ q_fv_ff.repel;
      neg_y = q_fv_ff.oy_neg ^ q_fv_ff.repel;
      lim_x = neg_x ? Q_W'(33'h0_8000_0000) : Q_W'(33'h0_7FFF_FFFF);
      lim_y = neg_y ? Q_W'(33'h0_8000_0000) : Q_W'(33'h0_7FFF_FFFF);
      ovr_x = (q_x_ff > lim_x);
      ovr_y = (q_y_ff > lim_y);
      v_x   = ovr_x ? lim_x[31:0] : q_x_ff[31:0];
      v_y   = ovr_y ? lim_y[31:0] : q_y_ff[31:0];
      if (q_fv_ff.inf) begin
         f_side_in.fx  = q_fv_ff.ox_neg ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         f_side_in.fy  = q_fv_ff.oy_neg ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         f_side_in.sat = 1'b1;
      end else begin
         f_side_in.fx  = neg_x ? (~v_x + 1'b1) : v_x;
         f_side_in.fy  = neg_y ? (~v_y + 1'b1) : v_y;
         f_side_in.sat = ovr_x | ovr_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff <= q_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_side_ff <= f_side_in;
      end
   end

   // heading of the force vector
   logic                 h_vld, h_zero;
   logic [31:0]          h_angle, h_round;
   pfv_pkg::cd_side_type h_side;

   pfv_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_vld_ff),
      .in_side   (f_side_ff),
      .out_valid (h_vld),
      .out_angle (h_angle),
      .out_zero  (h_zero),
      .out_side  (h_side)
   );

   // output register
   pfv_pkg::rsp_type rsp_data_in;

   assign h_round = h_angle + 32'h0000_8000;

   always_comb begin
      rsp_data_in.force_x   = h_side.fx;
      rsp_data_in.force_y   = h_side.fy;
      rsp_data_in.heading   = h_zero ? 16'sd0 : h_round[31:16];
      rsp_data_in.saturated = h_side.sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= h_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int          WATCHDOG_LIMIT = 4000;
   localparam int          DRAIN_CYCLES   = 120;
   localparam logic [2:0]  CSR_UNUSED     = 3'd7;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   pfv_pkg::req_type  req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   pfv_pkg::rsp_type  rsp_data;
   logic              csr_we = 1'b0;
   logic [2:0]        csr_index = '0;
   logic [31:0]       csr_wdata = '0;

   potential_field_force_vector_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // local copy of the field settings
   logic signed [31:0] cfg_centre_x = 0, cfg_centre_y = 0;
   logic [15:0]        cfg_attract = 256, cfg_repel = 256;
   logic [29:0]        cfg_radius = 65536, cfg_spread = 131072;

   pfv_pkg::req_type positions_pending[$];
   pfv_pkg::rsp_type forces_expected[$];
   int      mismatches = 0;
   int      beats_in = 0, beats_out = 0, sat_seen = 0, repel_seen = 0;
   bit      no_idle = 0;
   int      hold_request = 0;
   bit      req_took = 0, rsp_took = 0;
   int      quiet_cycles = 0;

   // arithmetic shift right, floor semantics
   function automatic longint shr(longint v, int s);
      return v >>> s;
   endfunction

   // binary angle of a force vector by cordic vectoring
   function automatic logic [15:0] heading_of(longint x, longint y);
      logic [31:0] z;
      longint      t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 16'd0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 32'h4000_0000;
         end else begin
            t = x; x = -y; y = t; z = 32'hC000_0000;
         end
      end
      for (int i = 0; i < pfv_pkg::CORDIC_STAGES && i < 24; i++) begin
         xs = shr(x, i);
         ys = shr(y, i);
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + pfv_pkg::atan_entry(i[4:0]);
         end else begin
            x = x - ys; y = y + xs; z = z - pfv_pkg::atan_entry(i[4:0]);
         end
      end
      z = z + 32'h8000;
      return z[31:16];
   endfunction

   // one force component: magnitude times cosine, clipped
   function automatic longint component(logic [127:0] m, logic [127:0] c, bit neg,
                                        inout bit sat);
      logic [127:0] v;
      logic [127:0] limit;
      v = (m * c) >> 38;
      limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (v > limit) begin
         v = limit;
         sat = 1;
      end
      return neg ? -longint'(v[63:0]) : longint'(v[63:0]);
   endfunction

   // expected force, heading and clip flag for one position
   function automatic pfv_pkg::rsp_type force_of(pfv_pkg::req_type p);
      pfv_pkg::rsp_type o;
      bit           repel, sat;
      longint       ox, oy, fx, fy;
      logic [127:0] ax, ay, sum, d, c, cx, cy, m, r, rs;
      repel = p.kind;
      sat = 0;
      ox = longint'(cfg_centre_x) - longint'(p.pos_x);
      oy = longint'(cfg_centre_y) - longint'(p.pos_y);
      ax = ox < 0 ? -ox : ox;
      ay = oy < 0 ? -oy : oy;
      sum = ax * ax + ay * ay;
      d = 0;
      for (int b = 33; b >= 0; b--) begin
         c = d | (128'd1 << b);
         if (c * c <= sum) d = c;
      end
      // robot on the centre points along angle zero
      if (d == 0) begin
         cx = 128'd1 << 30; cy = 0;
      end else begin
         cx = (ax << 30) / d; cy = (ay << 30) / d;
      end
      r = cfg_radius;
      rs = r + cfg_spread;
      m = 0;
      if (repel && d < r) begin
         fx = ox >= 0 ? -64'sd2147483648 : 64'sd2147483647;
         fy = oy >= 0 ? -64'sd2147483648 : 64'sd2147483647;
         sat = 1;
      end else begin
         if (!repel) begin
            if (d < r) m = 0;
            else if (d <= rs) m = cfg_attract * (d - r);
            else m = cfg_attract * cfg_spread;
         end else if (d <= rs) begin
            m = cfg_repel * (rs - d);
         end
         fx = component(m, cx, (ox < 0) != repel, sat);
         fy = component(m, cy, (oy < 0) != repel, sat);
      end
      o.force_x = fx[31:0];
      o.force_y = fy[31:0];
      o.heading = heading_of(fx, fy);
      o.saturated = sat;
      return o;
   endfunction

   // handshake sampling and result check
   always @(posedge clock) begin
      pfv_pkg::rsp_type exp_force;
      req_took <= req_valid && !req_stall && !reset;
      rsp_took <= rsp_valid && !rsp_stall && !reset;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            forces_expected.push_back(force_of(req_data));
            beats_in++;
            if (req_data.kind) repel_seen++;
         end
         if (rsp_valid && !rsp_stall) begin
            beats_out++;
            if (rsp_data.saturated) sat_seen++;
            if (forces_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat %p", rsp_data);
            end else begin
               exp_force = forces_expected.pop_front();
               if (rsp_data.force_x !== exp_force.force_x ||
                   rsp_data.force_y !== exp_force.force_y ||
                   rsp_data.heading !== exp_force.heading ||
                   rsp_data.saturated !== exp_force.saturated) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch at result %0d: expected %p, got %p",
                              beats_out, exp_force, rsp_data);
               end
            end
         end
      end
   end

   // watchdog on cycles with no accepted beat
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d results outstanding", forces_expected.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // position driver
   int send_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_took) begin
         // hold the offered beat
      end else if (send_gap > 0) begin
         send_gap <= send_gap - 1;
         req_valid <= 1'b0;
      end else if (positions_pending.size() > 0) begin
         req_data <= positions_pending.pop_front();
         req_valid <= 1'b1;
         send_gap <= no_idle ? 0 : $urandom_range(0, 5);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result receiver, with one long hold-off on request
   int stall_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_request > 0) begin
         hold_request <= hold_request - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (rsp_took && !no_idle) stall_left <= $urandom_range(0, 5);
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         pfv_pkg::CSR_CENTRE_X:     cfg_centre_x = val;
         pfv_pkg::CSR_CENTRE_Y:     cfg_centre_y = val;
         pfv_pkg::CSR_ATTRACT_GAIN: cfg_attract = val[15:0];
         pfv_pkg::CSR_REPEL_GAIN:   cfg_repel = val[15:0];
         pfv_pkg::CSR_CORE_RADIUS:  cfg_radius = val[29:0];
         pfv_pkg::CSR_FIELD_SPREAD: cfg_spread = val[29:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_field(logic [31:0] cx, logic [31:0] cy, logic [15:0] ga,
                              logic [15:0] gr, logic [29:0] rad, logic [29:0] spr);
      write_reg(pfv_pkg::CSR_CENTRE_X, cx);
      write_reg(pfv_pkg::CSR_CENTRE_Y, cy);
      write_reg(pfv_pkg::CSR_ATTRACT_GAIN, 32'(ga));
      write_reg(pfv_pkg::CSR_REPEL_GAIN, 32'(gr));
      write_reg(pfv_pkg::CSR_CORE_RADIUS, 32'(rad));
      write_reg(pfv_pkg::CSR_FIELD_SPREAD, 32'(spr));
   endtask

   task automatic add_position(bit kind, logic [31:0] x, logic [31:0] y);
      pfv_pkg::req_type p;
      p.kind = kind;
      p.pos_x = x;
      p.pos_y = y;
      positions_pending.push_back(p);
   endtask

   // mostly near the centre at a random scale, sometimes anywhere
   task automatic add_random_positions(int count);
      logic signed [31:0] dx, dy;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            add_position(1'($urandom_range(0, 1)), $urandom, $urandom);
         end else begin
            dx = $signed($urandom) >>> $urandom_range(0, 31);
            dy = $signed($urandom) >>> $urandom_range(0, 31);
            add_position(1'($urandom_range(0, 1)), cfg_centre_x + dx, cfg_centre_y + dy);
         end
      end
   endtask

   task automatic drain();
      while (positions_pending.size() > 0 || forces_expected.size() > 0 || req_valid)
         @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults: on the centre, radius edges, band, far field, extremes
      for (int k = 0; k < 2; k++) begin
         add_position(1'(k), 0, 0);
         add_position(1'(k), 32'h0000_8000, 0);
         add_position(1'(k), 32'h0001_0000, 0);
         add_position(1'(k), 0, 32'hFFFF_0000);
         add_position(1'(k), 32'h0002_0000, 32'h0001_0000);
         add_position(1'(k), 32'hFFFD_0000, 0);
         add_position(1'(k), 32'h0003_0000, 32'h0000_0001);
         add_position(1'(k), 32'h7FFF_FFFF, 32'h8000_0000);
         add_position(1'(k), 32'h8000_0000, 32'h7FFF_FFFF);
         add_position(1'(k), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      end
      drain();

      // unused register index must change nothing
      write_reg(CSR_UNUSED, $urandom);
      // large gains and sizes, centre at the negative corner
      write_field(32'h8000_0000, 32'h8000_0000, 16'hFFFF, 16'hFFFF,
                  30'h3FFF_FFFF, 30'h3FFF_FFFF);
      add_position(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_position(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_position(1, 32'h8000_0000, 32'h8000_0000);
      add_random_positions(40);
      drain();

      // zero radius and spread, first with zero gains and then with random ones
      write_field($urandom, $urandom, 16'h0000, 16'h0000, 0, 0);
      add_random_positions(30);
      drain();
      write_field($urandom, $urandom, 16'($urandom), 16'($urandom), 0, 0);
      add_random_positions(30);
      drain();

      // random settings, with one long receiver hold-off
      for (int ph = 0; ph < 5; ph++) begin
         write_field($urandom, $urandom, 16'($urandom), 16'($urandom),
                     30'($urandom_range(0, 1 << 22)), 30'($urandom_range(0, 1 << 22)));
         no_idle = (ph == 3);
         add_random_positions(60);
         if (ph == 1) begin
            @(negedge clock);
            hold_request = 400;
         end
         drain();
      end
      no_idle = 0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (forces_expected.size() > 0) begin
         mismatches++;
         $display("%0d expected results never arrived", forces_expected.size());
      end
      $display("covered %0d positions (%0d repulsive) over several field settings,",
               beats_in, repel_seen);
      $display("%0d results checked, %0d clipped, %0d mismatches",
               beats_out, sat_seen, mismatches);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
